// ===== rtl/affine_point_transform_unit_macros.svh =====
// Assertion macros shared by the affine point transform RTL.
`ifndef AFFINE_POINT_TRANSFORM_UNIT_MACROS_SVH
`define AFFINE_POINT_TRANSFORM_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked property check, disabled during reset.
`define APT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that must never hold.
`define APT_NEVER(lbl, expr, msg) `APT_ASSERT(lbl, !(expr), msg)
`else
`define APT_ASSERT(lbl, prop, msg)
`define APT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== rtl/apt_pkg.sv =====
// Types and constants of the affine point transform unit.
`default_nettype none
package apt_pkg;

  localparam int ROWS    = 3;
  localparam int COLS    = 4;
  localparam int DW      = 32;
  localparam int FRAC    = 16;
  localparam int PROD_W  = 2 * DW;
  localparam int ACC_W   = PROD_W + 2;
  localparam int SEL_W   = 2;
  localparam int SHIFT_W = ACC_W - FRAC;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_POS  = 2'd1,
    FUNC_DIR  = 2'd2
  } func_t;

  typedef logic signed [DW-1:0] entry_t;
  typedef entry_t [COLS-1:0]    row_t;
  typedef row_t   [ROWS-1:0]    matrix_t;

  // Stage advance strobes for the lanes and the merge stage.
  typedef struct packed {
    logic adv1;
    logic adv2;
    logic adv3;
  } pipe_ctl_t;

  typedef struct packed {
    entry_t value;
    logic   clip;
  } lane_res_t;

endpackage
`default_nettype wire

// ===== rtl/apt_req_if.sv =====
// Request channel: load or transform request.
`default_nettype none
interface apt_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [1:0]         row_sel;
  logic [1:0]         col_sel;
  logic signed [31:0] load_value;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;

  modport source (output valid, func, row_sel, col_sel, load_value, in_x, in_y, in_z,
                  input ready);
  modport sink (input valid, func, row_sel, col_sel, load_value, in_x, in_y, in_z,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/apt_res_if.sv =====
// Result channel: transformed vector and clip flag.
`default_nettype none
interface apt_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               saturated;

  modport source (output valid, out_x, out_y, out_z, saturated, input ready);
  modport sink (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface
`default_nettype wire

// ===== rtl/affine_point_transform_unit.sv =====
// Top level of the affine point transform unit.
//
//  channel | dir | payload                                       | handshake
//  --------+-----+-----------------------------------------------+------------
//  req     | in  | func, row_sel, col_sel, load_value, in_x/y/z  | valid/ready
//  res     | out | out_x, out_y, out_z, saturated                | valid/ready
//
// One request per cycle while req.ready is high. After acceptance a transform request
// passes through the multiply stage (nine 32x32 multipliers, three per lane), the sum
// stage (one 66-bit four-input add per lane) and the output register (clip merge).
// Load requests update the matrix at acceptance and give no result.
// Reset (rst, synchronous) zeroes the matrix and empties the pipeline.
// Each stage has its own valid bit, so bubbles close up while res is stalled;
// req.ready drops only when all three stages hold a result.
`default_nettype none
`include "affine_point_transform_unit_macros.svh"
module affine_point_transform_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  apt_req_if.sink    req,
  apt_res_if.source  res
);
  import apt_pkg::*;

  logic      take;
  logic      is_xform;
  logic      is_load;
  logic      v1, v2, v3;
  logic      s1_ready, s2_ready, s3_ready;
  pipe_ctl_t ctl;
  matrix_t   m;
  lane_res_t [2:0] lanes;

  // request decode; the unused function code does nothing
  assign take     = req.valid && req.ready;
  assign is_load  = req.func == FUNC_LOAD;
  assign is_xform = (req.func == FUNC_POS) || (req.func == FUNC_DIR);

  // per-stage flow control
  assign s3_ready  = !v3 || res.ready;
  assign s2_ready  = !v2 || s3_ready;
  assign s1_ready  = !v1 || s2_ready;
  assign req.ready = s1_ready;

  assign ctl.adv1 = take && is_xform;
  assign ctl.adv2 = v1 && s2_ready;
  assign ctl.adv3 = v2 && s3_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (s1_ready) v1 <= take && is_xform;
      if (s2_ready) v2 <= v1;
      if (s3_ready) v3 <= v2;
    end
  end

  apt_matrix u_matrix (
    .clk     (clk),
    .rst     (rst),
    .we      (take && is_load),
    .row_sel (req.row_sel),
    .col_sel (req.col_sel),
    .value   (req.load_value),
    .m       (m)
  );

  // one lane per matrix row
  for (genvar r = 0; r < ROWS; r++) begin : g_lane
    apt_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .row    (m[r]),
      .with_t (req.func == FUNC_POS),
      .x      (req.in_x),
      .y      (req.in_y),
      .z      (req.in_z),
      .res    (lanes[r])
    );
  end

  apt_merge u_merge (
    .clk       (clk),
    .ctl       (ctl),
    .lanes     (lanes),
    .out_x     (res.out_x),
    .out_y     (res.out_y),
    .out_z     (res.out_z),
    .saturated (res.saturated)
  );

  assign res.valid = v3;

  // backpressure only with a full pipeline
  `APT_NEVER(a_ready_low_only_full, !req.ready && !(v1 && v2 && v3), "req stalled with a free stage")
  // every accepted transform enters stage 1
  `APT_ASSERT(a_xform_enters, take && is_xform |=> v1, "transform request lost at entry")
  // loads and unused codes take no pipeline slot
  `APT_ASSERT(a_load_no_slot, take && !is_xform |=> !v1, "non-transform request made a result")
  // a blocked sum stage keeps its result
  `APT_ASSERT(a_stage2_held, v2 && !s2_ready |=> v2, "stage 2 result dropped while stalled")
endmodule
`default_nettype wire

// ===== rtl/apt_matrix.sv =====
// Matrix entry registers, 3 rows by 4 columns.
`default_nettype none
module apt_matrix (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     we,
  input  wire logic [apt_pkg::SEL_W-1:0] row_sel,
  input  wire logic [apt_pkg::SEL_W-1:0] col_sel,
  input  wire apt_pkg::entry_t          value,
  output apt_pkg::matrix_t              m
);
  import apt_pkg::*;

  logic row_ok;

  assign row_ok = row_sel < SEL_W'(ROWS);

  always_ff @(posedge clk) begin
    if (rst) begin
      m <= '0;
    end else if (we && row_ok) begin
      m[row_sel[1:0]][col_sel] <= value;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/apt_lane.sv =====
// One matrix row: three products, sum with translation, saturation.
`default_nettype none
module apt_lane (
  input  wire logic               clk,
  input  wire apt_pkg::pipe_ctl_t ctl,
  input  wire apt_pkg::row_t      row,
  input  wire logic               with_t,
  input  wire apt_pkg::entry_t    x,
  input  wire apt_pkg::entry_t    y,
  input  wire apt_pkg::entry_t    z,
  output apt_pkg::lane_res_t      res
);
  import apt_pkg::*;

  logic signed [PROD_W-1:0]  m0, m1, m2;
  logic signed [PROD_W-1:0]  p0, p1, p2;
  entry_t                    t;
  logic signed [ACC_W-1:0]   t_al;
  logic signed [ACC_W-1:0]   acc;
  logic signed [SHIFT_W-1:0] sh;
  logic                      fits;

  assign m0 = row[0] * x;
  assign m1 = row[1] * y;
  assign m2 = row[2] * z;

  // stage 1: products, translation taken at the same time
  always_ff @(posedge clk) begin
    if (ctl.adv1) begin
      p0 <= m0;
      p1 <= m1;
      p2 <= m2;
      t  <= with_t ? row[3] : '0;
    end
  end

  // translation aligned to Q32.32
  assign t_al = {{(ACC_W-DW-FRAC){t[DW-1]}}, t, {FRAC{1'b0}}};

  // stage 2: exact sum, never wraps at ACC_W bits
  always_ff @(posedge clk) begin
    if (ctl.adv2) begin
      acc <= ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2) + t_al;
    end
  end

  // arithmetic shift = floor, then clip to 32 bits
  assign sh   = acc[ACC_W-1:FRAC];
  assign fits = (&sh[SHIFT_W-1:DW-1]) || !(|sh[SHIFT_W-1:DW-1]);

  always_comb begin
    res.clip = !fits;
    if (fits) begin
      res.value = sh[DW-1:0];
    end else if (sh[SHIFT_W-1]) begin
      res.value = {1'b1, {(DW-1){1'b0}}};
    end else begin
      res.value = {1'b0, {(DW-1){1'b1}}};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/apt_merge.sv =====
// Output register: gathers the lane results and merges the clip flags.
`default_nettype none
module apt_merge (
  input  wire logic                           clk,
  input  wire apt_pkg::pipe_ctl_t             ctl,
  input  wire apt_pkg::lane_res_t [2:0]       lanes,
  output apt_pkg::entry_t                     out_x,
  output apt_pkg::entry_t                     out_y,
  output apt_pkg::entry_t                     out_z,
  output logic                                saturated
);
  import apt_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.adv3) begin
      out_x     <= lanes[0].value;
      out_y     <= lanes[1].value;
      out_z     <= lanes[2].value;
      saturated <= lanes[0].clip | lanes[1].clip | lanes[2].clip;
    end
  end
endmodule
`default_nettype wire
